@@ rtl/core/lah_pkg.sv @@
package lah_pkg;

    localparam int SUBSAMPLE_STEP = 16;
    localparam int MAX_DIMENSION  = 4096;

    localparam int LUMA_W     = 8;
    localparam int DIM_W      = 13;
    localparam int POS_W      = 12;
    localparam int SUM_W      = 24;
    localparam int CNT_W      = 17;
    localparam int TICK_W     = 16;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_CNT_W  = $clog2(SUM_W);

    localparam logic [LUMA_W-1:0] NO_SAMPLE_LEVEL = 8'd128;

    localparam logic [MODE_W-1:0] MODE_OFF  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ON   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_AUTO = 2'd2;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_IR_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DARK_THRESH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HYST_MARGIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_INTVL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd5;

    typedef struct packed {
        logic              mode;
        logic [LUMA_W-1:0] luma;
        logic              start_of_frame;
    } in_item_t;

    typedef struct packed {
        logic              led_on;
        logic [LUMA_W-1:0] brightness;
        logic              decided;
        logic              frame_done;
    } out_item_t;

    typedef struct packed {
        logic take;
        logic div_start;
        logic finish;
        logic push;
    } dp_cmd_t;

    typedef struct packed {
        logic div_needed;
        logic div_done;
    } dp_status_t;

    typedef enum logic {
        CTL_IDLE,
        CTL_DIV
    } ctl_state_t;

endpackage

@@ rtl/core/lah_div.sv @@
module lah_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [lah_pkg::SUM_W-1:0] dividend,
    input  logic [lah_pkg::CNT_W-1:0] divisor,
    output logic                      done,
    output logic [lah_pkg::SUM_W-1:0] quotient
);
    import lah_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0]     dvs_reg, dvs_next;
    logic [SUM_W-1:0]     quo_reg, quo_next;

    logic [CNT_W:0] rem_shift;
    logic [CNT_W:0] rem_sub;
    logic           fits;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[SUM_W-1]};
        rem_sub   = rem_shift - {1'b0, dvs_reg};
        fits      = rem_shift >= {1'b0, dvs_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;

        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[SUM_W-2:0], fits};
            rem_next  = fits ? rem_sub[CNT_W-1:0] : rem_shift[CNT_W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == DIV_CNT_W'(SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/core/lah_out_q.sv @@
module lah_out_q (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  lah_pkg::out_item_t push_data,
    output logic               room,
    output logic               out_valid,
    input  logic               out_stall,
    output lah_pkg::out_item_t out_data
);
    import lah_pkg::*;

    out_item_t  entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    always_comb
    begin
        pop         = (count_reg != 2'd0) && !out_stall;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign room      = count_reg != 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign out_data  = entry_reg[rd_ptr_reg];

endmodule

@@ rtl/core/lah_datapath.sv @@
module lah_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lah_pkg::in_item_t              in_data,
    input  logic                           cfg_write,
    input  logic [lah_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lah_pkg::CFG_DATA_W-1:0] cfg_data,
    input  lah_pkg::dp_cmd_t               cmd,
    output lah_pkg::dp_status_t            status,
    output lah_pkg::out_item_t             result
);
    import lah_pkg::*;

    logic [MODE_W-1:0] ir_mode_reg, ir_mode_next;
    logic [LUMA_W-1:0] thresh_reg, thresh_next;
    logic [LUMA_W-1:0] margin_reg, margin_next;
    logic [TICK_W-1:0] interval_reg, interval_next;
    logic [DIM_W-1:0]  width_reg, width_next;
    logic [DIM_W-1:0]  height_reg, height_next;

    logic [POS_W-1:0]  col_reg, col_next;
    logic [POS_W-1:0]  row_reg, row_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [TICK_W-1:0] elapsed_reg, elapsed_next;
    logic              led_reg, led_next;
    logic [LUMA_W-1:0] bright_reg, bright_next;

    logic [DIM_W-1:0]  w, h;
    logic [POS_W-1:0]  col0, row0, col1, row1;
    logic [SUM_W-1:0]  sum0, sum_acc;
    logic [CNT_W-1:0]  cnt0, cnt_acc;
    logic              sample, col_last, row_last, frame_end, check, is_pixel;
    logic              div_done;
    logic [SUM_W-1:0]  quotient;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        if (v == '0)
            return DIM_W'(1);
        else if (v > DIM_W'(MAX_DIMENSION))
            return DIM_W'(MAX_DIMENSION);
        else
            return v;
    endfunction

    function automatic logic hyst(input logic led, input logic [SUM_W-1:0] avg,
                                  input logic [LUMA_W-1:0] thr,
                                  input logic [LUMA_W-1:0] mrg);
        logic [LUMA_W:0] off_level;
        off_level = {1'b0, thr} + {1'b0, mrg};
        if (!led && (avg < SUM_W'(thr)))
            return 1'b1;
        else if (led && (avg > SUM_W'(off_level)))
            return 1'b0;
        else
            return led;
    endfunction

    lah_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_acc),
        .divisor  (cnt_acc),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        w    = clamp_dim(width_reg);
        h    = clamp_dim(height_reg);
        col0 = in_data.start_of_frame ? '0 : col_reg;
        row0 = in_data.start_of_frame ? '0 : row_reg;
        sum0 = in_data.start_of_frame ? '0 : sum_reg;
        cnt0 = in_data.start_of_frame ? '0 : cnt_reg;
        col1 = ({1'b0, col0} >= w) ? '0 : col0;
        row1 = ({1'b0, row0} >= h) ? '0 : row0;

        sample  = ((row1 % SUBSAMPLE_STEP) == 0) && ((col1 % SUBSAMPLE_STEP) == 0);
        sum_acc = sample ? sum0 + SUM_W'(in_data.luma) : sum0;
        cnt_acc = sample ? cnt0 + 1'b1 : cnt0;

        col_last  = ({1'b0, col1} + 1'b1) >= w;
        row_last  = ({1'b0, row1} + 1'b1) >= h;
        frame_end = col_last && row_last;
        is_pixel  = in_data.mode == KIND_PIXEL;
        check     = is_pixel && frame_end && (ir_mode_reg == MODE_AUTO)
                    && (elapsed_reg >= interval_reg);

        status.div_needed = check && (cnt_acc != '0);
        status.div_done   = div_done;
    end

    always_comb
    begin
        ir_mode_next  = ir_mode_reg;
        thresh_next   = thresh_reg;
        margin_next   = margin_reg;
        interval_next = interval_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        sum_next      = sum_reg;
        cnt_next      = cnt_reg;
        elapsed_next  = elapsed_reg;
        led_next      = led_reg;
        bright_next   = bright_reg;

        result.decided    = 1'b0;
        result.frame_done = 1'b0;

        if (cmd.take)
        begin
            if (!is_pixel)
            begin
                if (elapsed_reg != '1)
                    elapsed_next = elapsed_reg + 1'b1;
            end
            else if (frame_end)
            begin
                result.frame_done = 1'b1;
                col_next = '0;
                row_next = '0;
                sum_next = '0;
                cnt_next = '0;
                if (check)
                begin
                    elapsed_next = '0;
                    if (cnt_acc == '0)
                    begin
                        result.decided = 1'b1;
                        bright_next    = NO_SAMPLE_LEVEL;
                        led_next       = hyst(led_reg, SUM_W'(NO_SAMPLE_LEVEL),
                                              thresh_reg, margin_reg);
                    end
                end
            end
            else
            begin
                sum_next = sum_acc;
                cnt_next = cnt_acc;
                if (col_last)
                begin
                    col_next = '0;
                    row_next = row1 + 1'b1;
                end
                else
                begin
                    col_next = col1 + 1'b1;
                    row_next = row1;
                end
            end
        end

        if (cmd.finish)
        begin
            result.decided    = 1'b1;
            result.frame_done = 1'b1;
            bright_next       = quotient[LUMA_W-1:0];
            led_next          = hyst(led_reg, quotient, thresh_reg, margin_reg);
        end

        if (cfg_write)
        begin
            case (cfg_index)
                CFG_IR_MODE:
                begin
                    ir_mode_next = cfg_data[MODE_W-1:0];
                    if (cfg_data[MODE_W-1:0] == MODE_OFF)
                        led_next = 1'b0;
                    if (cfg_data[MODE_W-1:0] == MODE_ON)
                        led_next = 1'b1;
                end
                CFG_DARK_THRESH:  thresh_next   = cfg_data[LUMA_W-1:0];
                CFG_HYST_MARGIN:  margin_next   = cfg_data[LUMA_W-1:0];
                CFG_CHECK_INTVL:  interval_next = cfg_data[TICK_W-1:0];
                CFG_FRAME_WIDTH:  width_next    = cfg_data[DIM_W-1:0];
                CFG_FRAME_HEIGHT: height_next   = cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end

        result.led_on     = led_next;
        result.brightness = bright_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ir_mode_reg  <= MODE_AUTO;
            thresh_reg   <= 8'd40;
            margin_reg   <= 8'd15;
            interval_reg <= 16'd1000;
            width_reg    <= 13'd1280;
            height_reg   <= 13'd720;
            col_reg      <= '0;
            row_reg      <= '0;
            sum_reg      <= '0;
            cnt_reg      <= '0;
            elapsed_reg  <= '1;
            led_reg      <= 1'b0;
            bright_reg   <= '0;
        end
        else
        begin
            ir_mode_reg  <= ir_mode_next;
            thresh_reg   <= thresh_next;
            margin_reg   <= margin_next;
            interval_reg <= interval_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            sum_reg      <= sum_next;
            cnt_reg      <= cnt_next;
            elapsed_reg  <= elapsed_next;
            led_reg      <= led_next;
            bright_reg   <= bright_next;
        end
    end

endmodule

@@ rtl/core/lah_ctrl.sv @@
module lah_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                q_room,
    input  lah_pkg::dp_status_t status,
    output lah_pkg::dp_cmd_t    cmd
);
    import lah_pkg::*;

    ctl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= CTL_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        in_stall      = 1'b1;
        cmd.take      = 1'b0;
        cmd.div_start = 1'b0;
        cmd.finish    = 1'b0;
        cmd.push      = 1'b0;

        case (state_reg)
            CTL_IDLE:
            begin
                in_stall = !q_room;
                if (in_valid && q_room)
                begin
                    cmd.take = 1'b1;
                    if (status.div_needed)
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = CTL_DIV;
                    end
                    else
                        cmd.push = 1'b1;
                end
            end
            CTL_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.finish = 1'b1;
                    cmd.push   = 1'b1;
                    state_next = CTL_IDLE;
                end
            end
            default: state_next = CTL_IDLE;
        endcase
    end

    a_stall_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == CTL_DIV |-> in_stall)
        else $error("input taken while division runs");

    a_start_enters_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> state_reg == CTL_DIV)
        else $error("division started without waiting for it");

    a_done_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> state_reg == CTL_DIV)
        else $error("divider finished with no division pending");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> q_room)
        else $error("result pushed into a full queue");

endmodule

@@ rtl/core/luma_average_hysteresis_led.sv @@
// Average-brightness illuminator switch. Each accepted transaction is a luma pixel or a
// time tick and yields exactly one result. Ticks and ordinary pixels push their result as
// they are taken. The last pixel of a frame that runs a brightness check with at least one
// sample stalls the input while the floor average comes from a restoring divider, one
// quotient bit per cycle, after which hysteresis is applied. A two-entry result queue lets
// the input side keep going while one result waits downstream. Configuration writes are
// always ready and must only be issued while the block is idle.
module luma_average_hysteresis_led (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  lah_pkg::in_item_t              in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output lah_pkg::out_item_t             out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lah_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lah_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lah_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    out_item_t  result;
    logic       q_room;

    assign cfg_ready = 1'b1;

    lah_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .q_room   (q_room),
        .status   (status),
        .cmd      (cmd)
    );

    lah_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

    lah_out_q u_out_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd.push),
        .push_data (result),
        .room      (q_room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

@@ bench/lah_checker.sv @@
module lah_checker
    import lah_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  in_item_t              in_data,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  out_item_t             out_data,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatch_count,
    output int                    results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [MODE_W-1:0] ir_mode;
    logic [LUMA_W-1:0] dark_thr;
    logic [LUMA_W-1:0] hyst_margin;
    logic [TICK_W-1:0] interval;
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;

    logic [POS_W-1:0]  col;
    logic [POS_W-1:0]  row;
    logic [SUM_W-1:0]  luma_sum;
    logic [CNT_W-1:0]  luma_count;
    logic [TICK_W-1:0] ticks_since_check;
    logic              led;
    logic [LUMA_W-1:0] avg_luma;

    out_item_t pending_results[$];

    function automatic void clear_frame_stats();
        col = '0;
        row = '0;
        luma_sum = '0;
        luma_count = '0;
    endfunction

    function automatic int clamp_dim(input logic [DIM_W-1:0] d);
        if (d == '0)
            return 1;
        if (int'(d) > MAX_DIMENSION)
            return MAX_DIMENSION;
        return int'(d);
    endfunction

    // one result per transaction: pixel accumulation, frame end check, or tick count
    function automatic out_item_t step_brightness(input in_item_t it);
        out_item_t res;
        int w;
        int h;
        int mean;
        res = '0;
        if (it.mode == KIND_TICK) begin
            if (ticks_since_check != '1)
                ticks_since_check = ticks_since_check + 1'b1;
        end
        else begin
            w = clamp_dim(width_reg);
            h = clamp_dim(height_reg);
            if (it.start_of_frame)
                clear_frame_stats();
            if (int'(col) >= w)
                col = '0;
            if (int'(row) >= h)
                row = '0;
            if (int'(row) % SUBSAMPLE_STEP == 0 && int'(col) % SUBSAMPLE_STEP == 0) begin
                luma_sum = luma_sum + SUM_W'(it.luma);
                luma_count = luma_count + 1'b1;
            end
            if (int'(col) + 1 >= w) begin
                if (int'(row) + 1 >= h) begin
                    res.frame_done = 1'b1;
                    if (ir_mode == MODE_AUTO && ticks_since_check >= interval) begin
                        if (luma_count != '0)
                            mean = int'(luma_sum) / int'(luma_count);
                        else
                            mean = int'(NO_SAMPLE_LEVEL);
                        ticks_since_check = '0;
                        res.decided = 1'b1;
                        avg_luma = mean[LUMA_W-1:0];
                        if (!led && mean < int'(dark_thr))
                            led = 1'b1;
                        else if (led && mean > int'(dark_thr) + int'(hyst_margin))
                            led = 1'b0;
                    end
                    clear_frame_stats();
                end
                else begin
                    col = '0;
                    row = row + 1'b1;
                end
            end
            else begin
                col = col + 1'b1;
            end
        end
        res.led_on = led;
        res.brightness = avg_luma;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_item_t want;
        if (!rst_n) begin
            ir_mode = MODE_AUTO;
            dark_thr = 8'd40;
            hyst_margin = 8'd15;
            interval = 16'd1000;
            width_reg = 13'd1280;
            height_reg = 13'd720;
            clear_frame_stats();
            ticks_since_check = '1;
            led = 1'b0;
            avg_luma = '0;
            pending_results.delete();
            results_owed = 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_IR_MODE:
                    begin
                        ir_mode = cfg_data[MODE_W-1:0];
                        if (ir_mode == MODE_OFF)
                            led = 1'b0;
                        if (ir_mode == MODE_ON)
                            led = 1'b1;
                    end
                    CFG_DARK_THRESH:  dark_thr = cfg_data[LUMA_W-1:0];
                    CFG_HYST_MARGIN:  hyst_margin = cfg_data[LUMA_W-1:0];
                    CFG_CHECK_INTVL:  interval = cfg_data[TICK_W-1:0];
                    CFG_FRAME_WIDTH:  width_reg = cfg_data[DIM_W-1:0];
                    CFG_FRAME_HEIGHT: height_reg = cfg_data[DIM_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                pending_results.push_back(step_brightness(in_data));
            if (out_valid && !out_stall) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result with none expected, actual %p", $time, out_data);
                    mismatch_count++;
                end
                else begin
                    want = pending_results.pop_front();
                    if (out_data.led_on !== want.led_on) begin
                        $display("%0t: led_on expected %0b actual %0b",
                                 $time, want.led_on, out_data.led_on);
                        mismatch_count++;
                    end
                    if (out_data.brightness !== want.brightness) begin
                        $display("%0t: brightness expected %0d actual %0d",
                                 $time, want.brightness, out_data.brightness);
                        mismatch_count++;
                    end
                    if (out_data.decided !== want.decided) begin
                        $display("%0t: decided expected %0b actual %0b",
                                 $time, want.decided, out_data.decided);
                        mismatch_count++;
                    end
                    if (out_data.frame_done !== want.frame_done) begin
                        $display("%0t: frame_done expected %0b actual %0b",
                                 $time, want.frame_done, out_data.frame_done);
                        mismatch_count++;
                    end
                end
            end
            results_owed = pending_results.size();
        end
    end

endmodule

@@ bench/tb_luma_average_hysteresis_led.sv @@
module tb_luma_average_hysteresis_led;
    timeunit 1ns;
    timeprecision 1ps;

    import lah_pkg::*;

    localparam logic [MODE_W-1:0]    MODE_SPARE  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
    localparam int                   IN_W        = $bits(in_item_t);

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    in_item_t              in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int mismatch_count;
    int results_owed;
    int send_idle_pct;
    int recv_stall_pct;
    int eff_w;
    int eff_h;

    luma_average_hysteresis_led uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lah_checker led_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    initial
    begin
        #40_000_000;
        $display("FAIL luma_average_hysteresis_led");
        $finish;
    end

    function automatic in_item_t make_item(input logic kind, input int luma, input logic sof);
        in_item_t it;
        it.mode = kind;
        it.luma = luma[LUMA_W-1:0];
        it.start_of_frame = sof;
        return it;
    endfunction

    task automatic push_item(input in_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            in_data <= IN_W'($urandom_range(2 ** IN_W - 1));
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // wait until every transaction sent has its result back
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (results_owed != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic configure(input logic [MODE_W-1:0] mode, input int thr, input int hyst,
                             input int intvl, input int w, input int h);
        settle();
        write_reg(CFG_IR_MODE, int'(mode));
        write_reg(CFG_DARK_THRESH, thr);
        write_reg(CFG_HYST_MARGIN, hyst);
        write_reg(CFG_CHECK_INTVL, intvl);
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        eff_w = (w < 1) ? 1 : ((w > MAX_DIMENSION) ? MAX_DIMENSION : w);
        eff_h = (h < 1) ? 1 : ((h > MAX_DIMENSION) ? MAX_DIMENSION : h);
    endtask

    task automatic send_frame(input int first_luma, input int rest_luma);
        push_item(make_item(KIND_PIXEL, first_luma, 1'b1));
        repeat (eff_w * eff_h - 1)
            push_item(make_item(KIND_PIXEL, rest_luma, 1'b0));
    endtask

    // frames around a per-frame level, with ticks and stray or missing frame starts mixed in
    task automatic run_stream(input int n, input int tick_pct, input int noise_pct);
        int pos;
        int level;
        logic sof;
        pos = 0;
        level = $urandom_range(255);
        repeat (n) begin
            if ($urandom_range(99) < tick_pct) begin
                push_item(make_item(KIND_TICK, $urandom_range(255), 1'($urandom_range(1))));
            end
            else begin
                sof = (pos == 0);
                if ($urandom_range(99) < noise_pct)
                    sof = 1'($urandom_range(1));
                if (sof)
                    pos = 0;
                if (pos == 0)
                    level = $urandom_range(255);
                push_item(make_item(KIND_PIXEL, level ^ $urandom_range(15), sof));
                pos = (pos + 1) % (eff_w * eff_h);
            end
        end
    endtask

    initial
    begin
        send_idle_pct = 22;
        recv_stall_pct = 77;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // tiny frames: only the first pixel is sampled
        configure(MODE_AUTO, 40, 15, 1000, 2, 1);
        push_item(make_item(KIND_TICK, 255, 1'b1));
        send_frame(0, 255);
        push_item(make_item(KIND_TICK, 0, 1'b0));
        send_frame(255, 0);
        settle();
        write_reg(CFG_CHECK_INTVL, 0);
        send_frame(255, 0);
        send_frame(50, 0);
        send_frame(39, 0);
        send_frame(55, 0);
        send_frame(56, 0);
        push_item(make_item(KIND_PIXEL, 200, 1'b1));
        send_frame(10, 10);
        settle();
        write_reg(CFG_IR_MODE, int'(MODE_ON));
        send_frame(200, 200);
        settle();
        write_reg(CFG_IR_MODE, int'(MODE_SPARE));
        send_frame(0, 0);
        settle();
        write_reg(CFG_IR_MODE, int'(MODE_OFF));
        push_item(make_item(KIND_TICK, 0, 1'b0));
        settle();
        write_reg(CFG_SPARE_A, $urandom_range(65535));
        write_reg(CFG_SPARE_B, $urandom_range(65535));
        write_reg(CFG_IR_MODE, int'(MODE_AUTO));
        send_frame(0, 0);

        configure(MODE_AUTO, $urandom_range(255), $urandom_range(255), 3, 20, 18);
        run_stream(200, 10, 3);
        configure(MODE_AUTO, 255, 255, 2, 1, 1);
        run_stream(150, 30, 3);
        configure(MODE_AUTO, 0, 0, 0, 17, 33);
        run_stream(200, 5, 3);

        send_idle_pct = 77;
        recv_stall_pct = 22;
        configure(MODE_AUTO, $urandom_range(255), $urandom_range(255), 65535, 16, 16);
        run_stream(120, 20, 3);
        configure(MODE_ON, $urandom_range(255), $urandom_range(255), 1, 33, 17);
        run_stream(100, 10, 3);
        configure(MODE_SPARE, $urandom_range(255), $urandom_range(255), 0, 5, 3);
        run_stream(60, 10, 3);
        configure(MODE_AUTO, $urandom_range(255), $urandom_range(255), $urandom_range(8),
                  32, 32);
        run_stream(200, 15, 3);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        // out-of-range sizes clamped
        configure(MODE_AUTO, 128, 20, 0, 4096, 0);
        run_stream(40, 1, 0);
        configure(MODE_AUTO, 100, 50, 0, 0, 5000);
        run_stream(40, 1, 0);
        configure(MODE_OFF, $urandom_range(255), $urandom_range(255), 0, 3, 3);
        run_stream(40, 10, 3);
        configure(MODE_AUTO, $urandom_range(255), $urandom_range(255), $urandom_range(4),
                  $urandom_range(1, 24), $urandom_range(1, 24));
        run_stream(200, 10, 3);

        settle();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS luma_average_hysteresis_led");
        else
            $display("FAIL luma_average_hysteresis_led");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/lah_pkg.sv
rtl/core/lah_div.sv
rtl/core/lah_out_q.sv
rtl/core/lah_datapath.sv
rtl/core/lah_ctrl.sv
rtl/core/luma_average_hysteresis_led.sv
bench/lah_checker.sv
bench/tb_luma_average_hysteresis_led.sv
